@@ hw/rtl/reader_writer_lock_manager_core_defines.svh @@
// Assertion macros shared by the lock manager RTL.
`ifndef READER_WRITER_LOCK_MANAGER_CORE_DEFINES_SVH
`define READER_WRITER_LOCK_MANAGER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RWLM_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("lock manager check failed");

// Next-cycle implication, checked outside reset.
`define RWLM_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("lock manager check failed");

`endif

@@ hw/rtl/rwlm_pkg.sv @@
// Shared types, sizes and codes of the reader/writer lock manager.
package rwlm_pkg;

    localparam int LOCKS       = 16;
    localparam int LOCK_W      = $clog2(LOCKS);
    localparam int QUEUE_DEPTH = 8;
    localparam int QD_W        = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = QD_W + 1;
    localparam int TASKS       = 16;
    localparam int TASK_W      = $clog2(TASKS);
    localparam int COUNT_W     = 5;
    localparam int COUNT_MAX   = 31;
    localparam int WAITER_W    = TASK_W + 1;
    localparam int STORE_DEPTH = LOCKS * QUEUE_DEPTH;
    localparam int STORE_AW    = LOCK_W + QD_W;

    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 8;

    // Input item modes.
    localparam logic MODE_ACQUIRE = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_ACQUIRE = 2'd0;
    localparam logic [1:0] KIND_WOKEN   = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    // Error codes.
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_FULL      = 2'd1;
    localparam logic [1:0] ERR_UNDERFLOW = 2'd2;
    localparam logic [1:0] ERR_IN_GROUP  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic acq_exec;
        logic rel_exec;
        logic wake_read;
        logic wake_exec;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_release;
        logic freed;
        logic fill_zero;
        logic brk;
        logic stop;
        logic out_free;
    } t_status;

endpackage

@@ hw/rtl/rwlm_ram.sv @@
// Generic simple dual-port RAM with registered read.
module rwlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/rwlm_ctrl.sv @@
// Controller state machine of the lock manager.
module rwlm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  rwlm_pkg::t_status i_status,
    output rwlm_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_WAKE = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.out_free) begin
                    if (!i_status.is_release) begin
                        o_cmd.acq_exec = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        o_cmd.rel_exec = 1'b1;
                        n_state        = i_status.freed ? S_READ : S_IDLE;
                    end
                end
            end
            S_READ: begin
                if (i_status.fill_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.wake_read = 1'b1;
                    n_state         = S_WAKE;
                end
            end
            S_WAKE: begin
                if (i_status.out_free) begin
                    if (i_status.brk) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.wake_exec = 1'b1;
                        n_state         = i_status.stop ? S_FIN : S_READ;
                    end
                end
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ hw/rtl/rwlm_datapath.sv @@
// Lock table state, waiter store and output register of the lock manager.
module rwlm_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rwlm_pkg::t_cmd                    i_cmd,
    output rwlm_pkg::t_status                 o_status,
    input  logic [rwlm_pkg::IN_DATA_W-1:0]    i_in_data,
    input  logic                              i_in_mode,
    input  logic                              i_in_last,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [rwlm_pkg::OUT_DATA_W-1:0]   o_out_data,
    output logic [1:0]                        o_out_kind,
    output logic                              o_out_last
);

    // Captured input item.
    logic                          r_mode;
    logic [rwlm_pkg::TASK_W-1:0]   r_task;
    logic [rwlm_pkg::LOCK_W-1:0]   r_lock;
    logic                          r_excl;
    logic                          r_gend;

    // Lock table and per-task counts.
    logic [rwlm_pkg::COUNT_W-1:0]  r_shared [rwlm_pkg::LOCKS];
    logic [rwlm_pkg::COUNT_W-1:0]  n_shared [rwlm_pkg::LOCKS];
    logic                          r_xheld  [rwlm_pkg::LOCKS];
    logic                          n_xheld  [rwlm_pkg::LOCKS];
    logic [rwlm_pkg::QD_W-1:0]     r_head   [rwlm_pkg::LOCKS];
    logic [rwlm_pkg::QD_W-1:0]     n_head   [rwlm_pkg::LOCKS];
    logic [rwlm_pkg::FILL_W-1:0]   r_fill   [rwlm_pkg::LOCKS];
    logic [rwlm_pkg::FILL_W-1:0]   n_fill   [rwlm_pkg::LOCKS];
    logic [rwlm_pkg::COUNT_W-1:0]  r_pend   [rwlm_pkg::TASKS];
    logic [rwlm_pkg::COUNT_W-1:0]  n_pend   [rwlm_pkg::TASKS];
    logic                          r_group_open;
    logic                          n_group_open;
    logic                          r_group_waits;
    logic                          n_group_waits;

    // Output register.
    logic                          r_ov;
    logic                          n_ov;
    logic [1:0]                    r_kind;
    logic [rwlm_pkg::TASK_W-1:0]   r_otask;
    logic                          r_queued;
    logic                          r_wait;
    logic [1:0]                    r_err;
    logic                          r_olast;

    // Result built this cycle.
    logic                          emit;
    logic [1:0]                    e_kind;
    logic [rwlm_pkg::TASK_W-1:0]   e_task;
    logic                          e_queued;
    logic                          e_wait;
    logic [1:0]                    e_err;
    logic                          e_last;

    // Views of the selected lock.
    logic [rwlm_pkg::COUNT_W-1:0]  cur_shared;
    logic                          cur_xheld;
    logic [rwlm_pkg::QD_W-1:0]     cur_head;
    logic [rwlm_pkg::FILL_W-1:0]   cur_fill;
    logic                          must_queue;
    logic                          queue_full;
    logic                          freed;

    // Waiter store access.
    logic                          ram_we;
    logic [rwlm_pkg::STORE_AW-1:0] ram_waddr;
    logic [rwlm_pkg::WAITER_W-1:0] ram_wdata;
    logic [rwlm_pkg::STORE_AW-1:0] ram_raddr;
    logic [rwlm_pkg::WAITER_W-1:0] ram_rdata;
    logic [rwlm_pkg::TASK_W-1:0]   w_task;
    logic                          w_excl;

    assign cur_shared = r_shared[r_lock];
    assign cur_xheld  = r_xheld[r_lock];
    assign cur_head   = r_head[r_lock];
    assign cur_fill   = r_fill[r_lock];
    assign queue_full = (cur_fill == rwlm_pkg::FILL_W'(rwlm_pkg::QUEUE_DEPTH));
    assign must_queue = (cur_fill != '0) ||
                        (r_excl ? ((cur_shared != '0) || cur_xheld) : cur_xheld);
    assign freed      = !r_group_open &&
                        (r_excl || (cur_shared == rwlm_pkg::COUNT_W'(1)));

    assign w_task = ram_rdata[rwlm_pkg::WAITER_W-1:1];
    assign w_excl = ram_rdata[0];

    assign ram_we    = i_cmd.acq_exec && must_queue && !queue_full;
    assign ram_waddr = {r_lock, cur_head + cur_fill[rwlm_pkg::QD_W-1:0]};
    assign ram_wdata = {r_task, r_excl};
    assign ram_raddr = {r_lock, cur_head};

    rwlm_ram #(
        .WIDTH (rwlm_pkg::WAITER_W),
        .DEPTH (rwlm_pkg::STORE_DEPTH)
    ) u_waiters (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Status toward the controller.
    assign o_status.is_release = (r_mode == rwlm_pkg::MODE_RELEASE);
    assign o_status.freed      = freed;
    assign o_status.fill_zero  = (cur_fill == '0);
    assign o_status.brk        = w_excl && (cur_shared != '0);
    assign o_status.stop       = w_excl;
    assign o_status.out_free   = !r_ov || i_out_ready;

    // Table updates and result selection for each command.
    always_comb begin
        logic gw;
        n_shared      = r_shared;
        n_xheld       = r_xheld;
        n_head        = r_head;
        n_fill        = r_fill;
        n_pend        = r_pend;
        n_group_open  = r_group_open;
        n_group_waits = r_group_waits;
        emit          = 1'b0;
        e_kind        = rwlm_pkg::KIND_RELEASE;
        e_task        = '0;
        e_queued      = 1'b0;
        e_wait        = 1'b0;
        e_err         = rwlm_pkg::ERR_NONE;
        e_last        = 1'b1;
        gw            = r_group_open && r_group_waits;

        if (i_cmd.acq_exec) begin
            emit   = 1'b1;
            e_kind = rwlm_pkg::KIND_ACQUIRE;
            e_task = r_task;
            if (must_queue) begin
                if (queue_full) begin
                    e_err = rwlm_pkg::ERR_FULL;
                end else begin
                    n_fill[r_lock] = cur_fill + 1'b1;
                    if (r_pend[r_task] != rwlm_pkg::COUNT_W'(rwlm_pkg::COUNT_MAX)) begin
                        n_pend[r_task] = r_pend[r_task] + 1'b1;
                    end
                    e_queued = 1'b1;
                    gw       = 1'b1;
                end
            end else if (r_excl) begin
                n_xheld[r_lock] = 1'b1;
            end else if (cur_shared != rwlm_pkg::COUNT_W'(rwlm_pkg::COUNT_MAX)) begin
                n_shared[r_lock] = cur_shared + 1'b1;
            end
            e_wait        = r_gend && gw;
            n_group_open  = !r_gend;
            n_group_waits = !r_gend && gw;
        end

        if (i_cmd.rel_exec) begin
            if (r_group_open) begin
                emit  = 1'b1;
                e_err = rwlm_pkg::ERR_IN_GROUP;
            end else if (r_excl) begin
                n_xheld[r_lock] = 1'b0;
            end else if (cur_shared == '0) begin
                emit  = 1'b1;
                e_err = rwlm_pkg::ERR_UNDERFLOW;
            end else begin
                n_shared[r_lock] = cur_shared - 1'b1;
                emit             = !freed;
            end
        end

        // One waiter leaves the head of the queue.
        if (i_cmd.wake_exec) begin
            if (w_excl) begin
                n_xheld[r_lock] = 1'b1;
            end else if (cur_shared != rwlm_pkg::COUNT_W'(rwlm_pkg::COUNT_MAX)) begin
                n_shared[r_lock] = cur_shared + 1'b1;
            end
            n_head[r_lock] = cur_head + 1'b1;
            n_fill[r_lock] = cur_fill - 1'b1;
            if (r_pend[w_task] != '0) begin
                n_pend[w_task] = r_pend[w_task] - 1'b1;
                if (r_pend[w_task] == rwlm_pkg::COUNT_W'(1)) begin
                    emit   = 1'b1;
                    e_kind = rwlm_pkg::KIND_WOKEN;
                    e_task = w_task;
                    e_last = 1'b0;
                end
            end
        end

        if (i_cmd.finish) begin
            emit = 1'b1;
        end
    end

    assign n_ov = emit ? 1'b1 : (i_out_ready ? 1'b0 : r_ov);

    // Control and table state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rwlm_pkg::LOCKS; i++) begin
                r_shared[i] <= '0;
                r_xheld[i]  <= 1'b0;
                r_head[i]   <= '0;
                r_fill[i]   <= '0;
            end
            for (int t = 0; t < rwlm_pkg::TASKS; t++) begin
                r_pend[t] <= '0;
            end
            r_group_open  <= 1'b0;
            r_group_waits <= 1'b0;
            r_ov          <= 1'b0;
        end else begin
            r_shared      <= n_shared;
            r_xheld       <= n_xheld;
            r_head        <= n_head;
            r_fill        <= n_fill;
            r_pend        <= n_pend;
            r_group_open  <= n_group_open;
            r_group_waits <= n_group_waits;
            r_ov          <= n_ov;
        end
    end

    // Captured item and output payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_in_mode;
            r_task <= i_in_data[rwlm_pkg::TASK_W-1:0];
            r_lock <= i_in_data[4 +: rwlm_pkg::LOCK_W];
            r_excl <= i_in_data[8];
            r_gend <= i_in_last;
        end
        if (emit) begin
            r_kind   <= e_kind;
            r_otask  <= e_task;
            r_queued <= e_queued;
            r_wait   <= e_wait;
            r_err    <= e_err;
            r_olast  <= e_last;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = {r_err, r_wait, r_queued, r_otask};
    assign o_out_kind  = r_kind;
    assign o_out_last  = r_olast;

endmodule

@@ hw/rtl/reader_writer_lock_manager_core.sv @@
// Top level of the reader/writer lock manager.
//
// Input items arrive on the s_axis channel: tdata carries requester,
// lock_index and exclusive, tuser the mode (acquire or release) and
// tlast the end of an acquire group. Results leave on m_axis: tdata
// carries task_id, queued, must_wait and error, tuser the result kind
// and tlast the final result of an input item.
// One item is handled at a time. An acquire, or a release that leaves its
// lock held, is captured in IDLE and has its result registered in EXEC once
// the output register is free. A release that frees the lock then reads
// each waiter through the single read port of the waiter store in READ,
// updates the table in WAKE, stops at a writer and ends in FIN; the
// queue of a lock holds at most 8 waiters.
// The next item is accepted as soon as the previous one has produced its
// last result, even if that result still sits in the output register.
// When the receiver stalls, the output register holds its result and
// the engine waits before producing the next one.
// Synchronous reset clears all holder counts, flags, queues and pending
// counts; the waiter store needs no clearing.
`include "reader_writer_lock_manager_core_defines.svh"

module reader_writer_lock_manager_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [3:0] requester, [7:4] lock_index, [8] exclusive, [15:9] zero
    input  logic [rwlm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] mode
    input  logic [0:0]                      s_axis_tuser,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [3:0] task_id, [4] queued, [5] must_wait, [7:6] error
    output logic [rwlm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [1:0] kind
    output logic [1:0]                      m_axis_tuser,
    output logic                            m_axis_tlast
);

    rwlm_pkg::t_cmd    cmd;
    rwlm_pkg::t_status status;

    rwlm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rwlm_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (s_axis_tdata),
        .i_in_mode   (s_axis_tuser[0]),
        .i_in_last   (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_kind  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

    // Items are handled one at a time.
    `RWLM_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // A woken-task result is never the final result of a release.
    `RWLM_ASSERT_NOW(a_woken_not_last, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == rwlm_pkg::KIND_WOKEN), !m_axis_tlast)
    // An error always ends the item's results.
    `RWLM_ASSERT_NOW(a_error_last, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[7:6] != rwlm_pkg::ERR_NONE), m_axis_tlast)

endmodule
